// File: hw/rtl/swnh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_pkg: shared types and constants
// Opcodes, result limits, queue status and the sequencer states of the
// nearest wall crossing block.
// ----------------------------------------------------------------------------
package swnh_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int DIST_W = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

	localparam int CFG_W = 9;
	// register index decoded from paddr[2]
	localparam logic REG_WALL_COUNT = 1'b0;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ROOT
	} back_state_t;

endpackage : swnh_pkg
`default_nettype wire

// File: hw/rtl/swnh_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_queue: two-entry item queue
// Decouples the accepting front from the scanning back.
// ----------------------------------------------------------------------------
module swnh_queue import swnh_pkg::*; #(
	parameter int W = 74
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_item,
	input  wire logic         pop,
	output logic      [W-1:0] pop_item,
	output q_stat_t           stat
);

	logic [W-1:0] ent_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	// store pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign pop_item   = ent_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

endmodule : swnh_queue
`default_nettype wire

// File: hw/rtl/swnh_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_front: register port and item intake
// Holds wall_count, accepts beats, drops out-of-range loads and pushes the
// rest into the queue.
// ----------------------------------------------------------------------------
module swnh_front import swnh_pkg::*; #(
	parameter int MAX_WALLS  = 256,
	parameter int COORD_BITS = 16,
	localparam int IW = 4 * COORD_BITS + 10,
	localparam int CW = $clog2(MAX_WALLS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         op,
	input  wire logic [7:0]                   wall_index,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic                         end_of_batch,
	input  q_stat_t                           q_stat,
	output logic                              push,
	output logic      [IW-1:0]                push_item,
	output logic      [CW-1:0]                limit
);

	logic [CFG_W-1:0] wall_count_q;
	logic             accept;
	logic             slot_ok;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_WALL_COUNT)) begin
			wall_count_q <= pwdata[CFG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WALL_COUNT) ? 32'(wall_count_q) : 32'd0;

	// clamp the scan length to the table depth
	assign limit = (32'(wall_count_q) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count_q);

	// classify and push
	assign busy    = q_stat.full;
	assign accept  = start && !busy;
	assign slot_ok = (32'(wall_index) < MAX_WALLS);
	assign push    = accept && ((op == OP_QUERY) || slot_ok);
	assign push_item = {op, wall_index, start_x, start_y, end_x, end_y, end_of_batch};

endmodule : swnh_front
`default_nettype wire

// File: hw/rtl/swnh_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_div: serial scaled divider
// Computes floor(u * n / d) for n < d, one bit of u per cycle.
// ----------------------------------------------------------------------------
module swnh_div import swnh_pkg::*; #(
	parameter int UB = 16,
	parameter int NW = 34,
	parameter int DW = 35
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [UB-1:0] u,
	input  wire logic [NW-1:0] n,
	input  wire logic [DW-1:0] d,
	output logic               busy,
	output logic               done,
	output logic      [UB-1:0] q
);

	localparam int CNW = $clog2(UB + 1);

	logic [UB-1:0]  u_q;
	logic [NW-1:0]  n_q;
	logic [DW-1:0]  d_q;
	logic [DW-1:0]  r_q;
	logic [UB-1:0]  q_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW+1:0]  r2;
	logic [DW+1:0]  d1;
	logic [DW+1:0]  d2;
	logic [DW+1:0]  r_nx;
	logic [1:0]     k;

	// one restoring step: shift in a bit of u, take off d up to twice
	always_comb begin
		d1 = (DW+2)'(d_q);
		d2 = (DW+2)'({d_q, 1'b0});
		r2 = (DW+2)'({r_q, 1'b0}) + (u_q[UB-1] ? (DW+2)'(n_q) : '0);
		if (r2 >= d2) begin
			r_nx = r2 - d2;
			k    = 2'd2;
		end else if (r2 >= d1) begin
			r_nx = r2 - d1;
			k    = 2'd1;
		end else begin
			r_nx = r2;
			k    = 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			u_q <= u;
			n_q <= n;
			d_q <= d;
			r_q <= '0;
			q_q <= '0;
		end else if (busy_q) begin
			u_q <= {u_q[UB-2:0], 1'b0};
			r_q <= r_nx[DW-1:0];
			q_q <= UB'({q_q, 1'b0} + (UB+1)'(k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(UB - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign q    = q_q;

endmodule : swnh_div
`default_nettype wire

// File: hw/rtl/swnh_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_sqrt: serial integer square root
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module swnh_sqrt import swnh_pkg::*; #(
	parameter int XW = 33,
	localparam int EW = XW + (XW % 2),
	localparam int NS = EW / 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [XW-1:0] x,
	output logic               done,
	output logic      [NS-1:0] root
);

	localparam int CNW = $clog2(NS + 1);

	logic [EW-1:0]  x_q;
	logic [NS:0]    rem_q;
	logic [NS-1:0]  root_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [NS+2:0]  rem2;
	logic [NS+2:0]  trial;
	logic           take;

	// bring down two bits, try root*4+1
	always_comb begin
		rem2  = {rem_q, x_q[EW-1:EW-2]};
		trial = (NS+3)'({root_q, 2'b01});
		take  = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= EW'(x);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[EW-3:0], 2'b00};
			rem_q  <= take ? (NS+1)'(rem2 - trial) : (NS+1)'(rem2);
			root_q <= {root_q[NS-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(NS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule : swnh_sqrt
`default_nettype wire

// File: hw/rtl/swnh_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swnh_back: wall table and query scan
// Writes loads into the wall table; for a query streams the walls through a
// four-stage orientation pipeline, divides out each crossing, keeps the
// least squared offset and takes its square root.
// ----------------------------------------------------------------------------
module swnh_back import swnh_pkg::*; #(
	parameter int MAX_WALLS  = 256,
	parameter int COORD_BITS = 16,
	localparam int IW = 4 * COORD_BITS + 10,
	localparam int CW = $clog2(MAX_WALLS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  q_stat_t                q_stat,
	input  wire logic [IW-1:0]     q_item,
	output logic                   q_pop,
	input  wire logic [CW-1:0]     limit,
	output logic                   done,
	output logic                   hit,
	output logic      [DIST_W-1:0] distance,
	output logic                   last_result
);

	localparam int C   = COORD_BITS;
	localparam int AW  = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int PW  = 2 * C + 2;
	localparam int OW  = 2 * C + 3;
	localparam int MW  = 2 * C + 2;
	localparam int DW  = 2 * C + 3;
	localparam int SQW = 2 * C + 1;
	localparam int NS  = C + 1;
	localparam int XW  = (NS > DIST_W) ? NS : DIST_W;

	function automatic logic signed [C:0] sdiff(input logic signed [C-1:0] p,
	                                            input logic signed [C-1:0] r);
		return {p[C-1], p} - {r[C-1], r};
	endfunction

	function automatic logic opp(input logic signed [OW-1:0] p,
	                             input logic signed [OW-1:0] r);
		return ((p < 0) && (r > 0)) || ((p > 0) && (r < 0));
	endfunction

	back_state_t state_q, state_nx;

	// item fields
	logic                  it_op;
	logic [7:0]            it_idx;
	logic signed [C-1:0]   it_ax, it_ay, it_bx, it_by;
	logic                  it_last;
	logic signed [C:0]     it_qx, it_qy;

	// query registers
	logic signed [C-1:0]   ax_q, ay_q, bx_q, by_q;
	logic signed [C:0]     qx_q, qy_q;
	logic [C-1:0]          ux_q, uy_q;
	logic                  last_q;
	logic [CW-1:0]         issue_q;
	logic                  hit_q;
	logic [SQW-1:0]        best_q;

	// wall table
	logic [4*C-1:0]        mem [MAX_WALLS];

	// pipeline
	logic                  stall;
	logic                  issue;
	logic                  v_s1, v_s2, v_s3, v_s4, v_sq_s1;
	logic [4*C-1:0]        rd_s1;
	logic signed [C-1:0]   cx, cy, dx, dy;
	logic signed [C:0]     wx_s2, wy_s2, acx_s2, acy_s2, bcx_s2, bcy_s2;
	logic signed [C:0]     cax_s2, cay_s2, dax_s2, day_s2;
	logic signed [PW-1:0]  p0_s3, p1_s3, p2_s3, p3_s3, p4_s3, p5_s3, p6_s3, p7_s3;
	logic signed [OW-1:0]  oa, ob, oc, od;
	logic [MW-1:0]         ma, mb;
	logic                  cross_s4;
	logic [MW-1:0]         ma_s4;
	logic [DW-1:0]         d_s4;
	logic                  div_go;
	logic                  divx_busy, divy_busy, divx_done, divy_done;
	logic [C-1:0]          ox, oy;
	logic [2*C-1:0]        sqx_s1, sqy_s1;
	logic [SQW-1:0]        dsq;

	// control
	logic                  mem_we;
	logic                  take_query;
	logic                  scan_done;
	logic                  root_go;
	logic                  root_done;
	logic [NS-1:0]         root;
	logic [XW-1:0]         root_x;
	logic                  done_q;
	logic                  hit_out_q;
	logic [DIST_W-1:0]     dist_q;
	logic                  last_out_q;

	// unpack the queue head
	assign it_op   = q_item[IW-1];
	assign it_idx  = q_item[IW-2 -: 8];
	assign it_ax   = q_item[4*C -: C];
	assign it_ay   = q_item[3*C -: C];
	assign it_bx   = q_item[2*C -: C];
	assign it_by   = q_item[C -: C];
	assign it_last = q_item[0];
	assign it_qx   = sdiff(it_bx, it_ax);
	assign it_qy   = sdiff(it_by, it_ay);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty && (it_op == OP_QUERY)) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_nx = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (root_done) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop      = 1'b0;
		mem_we     = 1'b0;
		take_query = 1'b0;
		root_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop      = !q_stat.empty;
				mem_we     = !q_stat.empty && (it_op == OP_LOAD);
				take_query = !q_stat.empty && (it_op == OP_QUERY);
			end
			ST_SCAN: begin
				root_go = scan_done;
			end
			ST_ROOT: begin
				q_pop = 1'b0;
			end
			default: q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// latch the query segment
	always_ff @(posedge clk) begin
		if (take_query) begin
			ax_q   <= it_ax;
			ay_q   <= it_ay;
			bx_q   <= it_bx;
			by_q   <= it_by;
			qx_q   <= it_qx;
			qy_q   <= it_qy;
			ux_q   <= it_qx[C] ? C'(-it_qx) : C'(it_qx);
			uy_q   <= it_qy[C] ? C'(-it_qy) : C'(it_qy);
			last_q <= it_last;
		end
	end

	// wall table write and registered read
	assign stall = divx_busy || divy_busy;
	assign issue = (state_q == ST_SCAN) && (issue_q < limit) && !stall;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(it_idx)] <= q_item[4*C:1];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem[issue_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= '0;
		end else if (take_query) begin
			issue_q <= '0;
		end else if (issue) begin
			issue_q <= issue_q + 1'b1;
		end
	end

	// stage 2: coordinate differences
	assign cx = rd_s1[4*C-1 -: C];
	assign cy = rd_s1[3*C-1 -: C];
	assign dx = rd_s1[2*C-1 -: C];
	assign dy = rd_s1[C-1 -: C];

	always_ff @(posedge clk) begin
		if (!stall) begin
			wx_s2  <= sdiff(dx, cx);
			wy_s2  <= sdiff(dy, cy);
			acx_s2 <= sdiff(ax_q, cx);
			acy_s2 <= sdiff(ay_q, cy);
			bcx_s2 <= sdiff(bx_q, cx);
			bcy_s2 <= sdiff(by_q, cy);
			cax_s2 <= sdiff(cx, ax_q);
			cay_s2 <= sdiff(cy, ay_q);
			dax_s2 <= sdiff(dx, ax_q);
			day_s2 <= sdiff(dy, ay_q);
		end
	end

	// stage 3: cross product terms
	always_ff @(posedge clk) begin
		if (!stall) begin
			p0_s3 <= PW'(wx_s2) * PW'(acy_s2);
			p1_s3 <= PW'(wy_s2) * PW'(acx_s2);
			p2_s3 <= PW'(wx_s2) * PW'(bcy_s2);
			p3_s3 <= PW'(wy_s2) * PW'(bcx_s2);
			p4_s3 <= PW'(qx_q) * PW'(cay_s2);
			p5_s3 <= PW'(qy_q) * PW'(cax_s2);
			p6_s3 <= PW'(qx_q) * PW'(day_s2);
			p7_s3 <= PW'(qy_q) * PW'(dax_s2);
		end
	end

	// stage 4: orientations and the proper crossing test
	always_comb begin
		oa = OW'(p0_s3) - OW'(p1_s3);
		ob = OW'(p2_s3) - OW'(p3_s3);
		oc = OW'(p4_s3) - OW'(p5_s3);
		od = OW'(p6_s3) - OW'(p7_s3);
		ma = oa[OW-1] ? MW'(-oa) : MW'(oa);
		mb = ob[OW-1] ? MW'(-ob) : MW'(ob);
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			cross_s4 <= opp(oa, ob) && opp(oc, od);
			ma_s4    <= ma;
			d_s4     <= DW'(ma) + DW'(mb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// divide out a crossing on both axes
	assign div_go = v_s4 && cross_s4 && !stall;

	swnh_div #(.UB(C), .NW(MW), .DW(DW)) u_divx (
		.clk(clk), .arst_n(arst_n), .go(div_go), .u(ux_q), .n(ma_s4), .d(d_s4),
		.busy(divx_busy), .done(divx_done), .q(ox)
	);

	swnh_div #(.UB(C), .NW(MW), .DW(DW)) u_divy (
		.clk(clk), .arst_n(arst_n), .go(div_go), .u(uy_q), .n(ma_s4), .d(d_s4),
		.busy(divy_busy), .done(divy_done), .q(oy)
	);

	// square the offsets
	always_ff @(posedge clk) begin
		if (divx_done) begin
			sqx_s1 <= (2*C)'(ox) * (2*C)'(ox);
			sqy_s1 <= (2*C)'(oy) * (2*C)'(oy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq_s1 <= 1'b0;
		end else begin
			v_sq_s1 <= divx_done && divy_done;
		end
	end

	// keep the least squared distance
	assign dsq = SQW'(sqx_s1) + SQW'(sqy_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (take_query) begin
			hit_q <= 1'b0;
		end else if (v_sq_s1) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_sq_s1 && (!hit_q || (dsq < best_q))) begin
			best_q <= dsq;
		end
	end

	assign scan_done = (issue_q == limit) && !v_s1 && !v_s2 && !v_s3 && !v_s4 &&
	                   !divx_busy && !divx_done && !v_sq_s1;

	// square root of the best distance
	swnh_sqrt #(.XW(SQW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .go(root_go), .x(best_q),
		.done(root_done), .root(root)
	);

	assign root_x = XW'(root);

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_ROOT) && root_done;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_ROOT) && root_done) begin
			hit_out_q  <= hit_q;
			last_out_q <= last_q;
			if (!hit_q || (root_x > XW'(DIST_MAX))) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= root_x[DIST_W-1:0];
			end
		end
	end

	assign done        = done_q;
	assign hit         = hit_out_q;
	assign distance    = dist_q;
	assign last_result = last_out_q;

endmodule : swnh_back
`default_nettype wire

// File: hw/rtl/segment_wall_nearest_hit_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segment_wall_nearest_hit_distance: nearest wall crossing along a segment
// Loads wall segments into a table and, per query, reports whether the
// query properly crosses a wall and the distance to the nearest crossing.
//
//   channel  direction  handshake               beat
//   config   in/out     psel/penable/pready     wall_count at paddr 0
//   item     in         start & !busy           op, wall_index, coords, eob
//   result   out        done (one cycle)        hit, distance, last_result
//
// A load is written into the wall table from the queue head once the scan
// side is idle. A query scans the table, one wall read per cycle while no
// divide is in progress; each crossing stalls the scan for a divide on both
// axes, and a square root of the best distance follows the scan.
// busy rises when the two-entry queue is full. Reset clears all control
// state; the wall table holds no reset and must be loaded before use.
// ----------------------------------------------------------------------------
module segment_wall_nearest_hit_distance import swnh_pkg::*; #(
	parameter int MAX_WALLS  = 256,
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         op,
	input  wire logic [7:0]                   wall_index,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic                         end_of_batch,
	output logic                              done,
	output logic                              hit,
	output logic      [DIST_W-1:0]            distance,
	output logic                              last_result
);

	localparam int IW = 4 * COORD_BITS + 10;
	localparam int CW = $clog2(MAX_WALLS + 1);

	q_stat_t        q_stat;
	logic           push;
	logic [IW-1:0]  push_item;
	logic           pop;
	logic [IW-1:0]  pop_item;
	logic [CW-1:0]  limit;

	// intake and register port
	swnh_front #(.MAX_WALLS(MAX_WALLS), .COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .op(op), .wall_index(wall_index),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.end_of_batch(end_of_batch), .q_stat(q_stat),
		.push(push), .push_item(push_item), .limit(limit)
	);

	// decoupling queue
	swnh_queue #(.W(IW)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.pop(pop), .pop_item(pop_item), .stat(q_stat)
	);

	// table and scan
	swnh_back #(.MAX_WALLS(MAX_WALLS), .COORD_BITS(COORD_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_stat(q_stat), .q_item(pop_item),
		.q_pop(pop), .limit(limit), .done(done), .hit(hit),
		.distance(distance), .last_result(last_result)
	);

`ifndef SYNTHESIS
	// a result beat is never followed directly by another
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// the queue fills only by accepting a beat
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");

	// a miss reports the saturated distance
	a_miss_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (distance == DIST_MAX))
		else $error("miss with a finite distance");
`endif

endmodule : segment_wall_nearest_hit_distance
`default_nettype wire

// File: tb/sv/segment_wall_nearest_hit_distance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_wall_nearest_hit_distance_tb: self-checking bench for the wall block
// Loads wall tables, sets wall_count over the APB port and sends query beats.
// Every query's hit flag, distance and batch echo are checked in order
// against a behavioral crossing predictor kept inside the bench.
// ----------------------------------------------------------------------------
module segment_wall_nearest_hit_distance_tb;
	import swnh_pkg::*;

	typedef struct {
		logic              hit;
		logic [DIST_W-1:0] distance;
		logic              last;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic op = OP_LOAD;
	logic [7:0] wall_index = '0;
	logic signed [15:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic end_of_batch = 1'b0;
	logic done, hit, last_result;
	logic [DIST_W-1:0] distance;

	// predictor state
	logic signed [15:0] wall_cx [256];
	logic signed [15:0] wall_cy [256];
	logic signed [15:0] wall_dx [256];
	logic signed [15:0] wall_dy [256];
	bit loaded [256];
	int unsigned tested_walls = 0;
	crossing_t pending_crossings [$];
	int unsigned fails = 0;
	bit steady = 1'b0;

	segment_wall_nearest_hit_distance dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.op(op), .wall_index(wall_index),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.end_of_batch(end_of_batch),
		.done(done), .hit(hit), .distance(distance), .last_result(last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint orient(longint ox, longint oy, longint px, longint py,
			longint qx, longint qy);
		return (px - ox) * (qy - oy) - (py - oy) * (qx - ox);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned x);
		longint unsigned res;
		longint unsigned t;
		res = 0;
		for (int b = 17; b >= 0; b--) begin
			t = res | (64'd1 << b);
			if (t * t <= x)
				res = t;
		end
		return res;
	endfunction

	// scan the table the way the block does and keep the nearest crossing
	function automatic crossing_t nearest_crossing(longint ax, longint ay, longint bx,
			longint by, logic eob);
		crossing_t r;
		longint oa, ob, oc, od;
		longint unsigned ma, mb, ox, oy, dsq, best, rt;
		int unsigned n;
		best = 0;
		r.hit = 1'b0;
		r.last = eob;
		n = (tested_walls > 256) ? 256 : tested_walls;
		for (int j = 0; j < n; j++) begin
			oa = orient(wall_cx[j], wall_cy[j], wall_dx[j], wall_dy[j], ax, ay);
			ob = orient(wall_cx[j], wall_cy[j], wall_dx[j], wall_dy[j], bx, by);
			oc = orient(ax, ay, bx, by, wall_cx[j], wall_cy[j]);
			od = orient(ax, ay, bx, by, wall_dx[j], wall_dy[j]);
			if (!(((oa > 0 && ob < 0) || (oa < 0 && ob > 0)) &&
					((oc > 0 && od < 0) || (oc < 0 && od > 0))))
				continue;
			ma = (oa < 0) ? -oa : oa;
			mb = (ob < 0) ? -ob : ob;
			ox = ((bx > ax) ? bx - ax : ax - bx) * ma / (ma + mb);
			oy = ((by > ay) ? by - ay : ay - by) * ma / (ma + mb);
			dsq = ox * ox + oy * oy;
			if (!r.hit || dsq < best)
				best = dsq;
			r.hit = 1'b1;
		end
		rt = root_floor(best);
		r.distance = (!r.hit || rt > DIST_MAX) ? DIST_MAX : rt[DIST_W-1:0];
		return r;
	endfunction

	// check each result beat against the oldest prediction
	always @(posedge clk) begin
		crossing_t e;
		if (arst_n && done) begin
			if (pending_crossings.size() == 0) begin
				$display("%0t: unexpected result hit=%0b distance=%0d last=%0b",
					$time, hit, distance, last_result);
				fails++;
			end else begin
				e = pending_crossings.pop_front();
				if (hit !== e.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
					fails++;
				end
				if (distance !== e.distance) begin
					$display("%0t: distance expected %0d actual %0d",
						$time, e.distance, distance);
					fails++;
				end
				if (last_result !== e.last) begin
					$display("%0t: last_result expected %0b actual %0b",
						$time, e.last, last_result);
					fails++;
				end
			end
		end
	end

	// drive one beat, hold until accepted, then predict
	task automatic send_item(logic o, logic [7:0] idx, logic signed [15:0] ax,
			logic signed [15:0] ay, logic signed [15:0] bx, logic signed [15:0] by,
			logic eob);
		@(negedge clk);
		op = o; wall_index = idx; end_of_batch = eob;
		start_x = ax; start_y = ay; end_x = bx; end_y = by;
		start = 1'b1;
		do @(posedge clk); while (busy);
		if (o == OP_LOAD) begin
			wall_cx[idx] = ax; wall_cy[idx] = ay;
			wall_dx[idx] = bx; wall_dy[idx] = by;
			loaded[idx] = 1'b1;
		end else begin
			pending_crossings.push_back(nearest_crossing(ax, ay, bx, by, eob));
		end
		// random gap after the beat
		if (!steady && $urandom_range(99) < 34) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	endtask

	// drop start and let the block finish everything in flight
	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		wait (pending_crossings.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_wall_count(int unsigned val);
		drain();
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {REG_WALL_COUNT, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		tested_walls = val & 32'h1FF;
	endtask

	// longest run of loaded slots from slot zero
	function automatic int unsigned loaded_prefix();
		int unsigned n;
		n = 0;
		while (n < 256 && loaded[n])
			n++;
		return n;
	endfunction

	function automatic logic signed [15:0] coord(bit near);
		if (near)
			return $signed($urandom_range(0, 400)) - 200;
		return $urandom;
	endfunction

	task automatic send_random_query(bit near);
		send_item(OP_QUERY, $urandom, coord(near), coord(near), coord(near), coord(near),
			$urandom_range(1));
	endtask

	task automatic test_empty_table;
		write_wall_count(0);
		send_item(OP_QUERY, 8'h00, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0);
		send_item(OP_QUERY, 8'hFF, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1'b1);
	endtask

	task automatic test_directed_crossings;
		// vertical wall, horizontal wall, extreme diagonal, collinear with x axis
		send_item(OP_LOAD, 8'd0, 16'sd0, -16'sd160, 16'sd0, 16'sd160, 1'b0);
		send_item(OP_LOAD, 8'd1, -16'sd320, 16'sd48, 16'sd320, 16'sd48, 1'b1);
		send_item(OP_LOAD, 8'd2, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 1'b0);
		send_item(OP_LOAD, 8'd3, 16'sd100, 16'sd0, 16'sd300, 16'sd0, 1'b0);
		send_item(OP_LOAD, 8'd255, 16'sd5, 16'sd5, -16'sd5, -16'sd5, 1'b0);
		write_wall_count(4);
		// plain crossing of walls 0 and 2
		send_item(OP_QUERY, 8'd0, -16'sd100, -16'sd3, 16'sd100, 16'sd7, 1'b0);
		// crossing several walls, nearest wins
		send_item(OP_QUERY, 8'd9, -16'sd50, -16'sd50, 16'sd60, 16'sd200, 1'b1);
		// endpoint touches a wall: not a crossing
		send_item(OP_QUERY, 8'd0, -16'sd30, 16'sd100, 16'sd0, 16'sd100, 1'b0);
		// collinear overlap with wall 3
		send_item(OP_QUERY, 8'd0, 16'sd50, 16'sd0, 16'sd400, 16'sd0, 1'b0);
		// passes through a wall endpoint
		send_item(OP_QUERY, 8'd0, -16'sd10, 16'sd150, 16'sd10, 16'sd170, 1'b0);
		// longest segment across the whole plane
		send_item(OP_QUERY, 8'd0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1);
		send_item(OP_QUERY, 8'd0, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32767, 1'b0);
		// zero length query
		send_item(OP_QUERY, 8'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
	endtask

	task automatic test_random_phases;
		int unsigned lim;
		for (int p = 0; p < 9; p++) begin
			steady = (p == 5);
			lim = loaded_prefix();
			if (lim > 20)
				lim = 20;
			write_wall_count((p == 0) ? lim : $urandom_range(0, lim));
			repeat (40) begin
				if ($urandom_range(99) < 30)
					send_item(OP_LOAD, ($urandom_range(99) < 70) ? $urandom_range(0, 23) :
						$urandom, coord(p[0]), coord(p[0]), coord(p[0]), coord(p[0]),
						$urandom_range(1));
				else
					send_random_query($urandom_range(1));
			end
		end
		steady = 1'b0;
	endtask

	task automatic test_full_table;
		for (int i = 0; i < 256; i++)
			send_item(OP_LOAD, i, coord(1'b1), coord(1'b1), coord(1'b1), coord(1'b1), 1'b0);
		write_wall_count(256);
		repeat (4) send_random_query($urandom_range(1));
		// beyond the table, clamps to the full table
		write_wall_count(300);
		repeat (3) send_random_query(1'b1);
		write_wall_count(511);
		repeat (3) send_random_query(1'b0);
		write_wall_count(1);
		repeat (10) send_random_query(1'b1);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_directed_crossings();
		test_random_phases();
		test_full_table();
		drain();
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/swnh_pkg.sv
hw/rtl/swnh_queue.sv
hw/rtl/swnh_front.sv
hw/rtl/swnh_div.sv
hw/rtl/swnh_sqrt.sv
hw/rtl/swnh_back.sv
hw/rtl/segment_wall_nearest_hit_distance.sv
tb/sv/segment_wall_nearest_hit_distance_tb.sv
